// ===== hw/rtl/prmt_pkg.sv =====
// Shared types, codes and single-precision helpers for the range motion tracker.
// No dependencies; every other file refers to this package by scoped names.
package prmt_pkg;

  localparam int unsigned CH_W = 4;
  localparam logic [31:0] FLOOR_RESET   = 32'h3586_37BD;
  localparam logic [31:0] CEILING_RESET = 32'h4974_2400;
  localparam logic [31:0] EXP_MASK      = 32'h7F80_0000;
  localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OUT_IGNORED = 2'd0,
    OUT_OUTSIDE = 2'd1,
    OUT_INSIDE  = 2'd2,
    OUT_CLEARED = 2'd3
  } outcome_t;

  typedef enum logic {
    REG_FLOOR   = 1'b0,
    REG_CEILING = 1'b1
  } reg_index_t;

  typedef struct packed {
    outcome_t         outcome;
    logic             ok;
    logic [CH_W-1:0]  channel;
    logic [31:0]      value;
  } item_t;

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sign;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [3:0]  sh;
    logic [20:0] shifted;
    logic [7:0]  ex;
    sign = {h[15], 31'd0};
    e    = h[14:10];
    m    = h[9:0];
    p    = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    sh      = 4'd10 - p;
    shifted = {11'd0, m} << sh;
    ex      = 8'd113 - {4'd0, sh};
    if (e == 5'd0) begin
      if (m == 10'd0) return sign;
      return sign | {1'b0, ex, shifted[9:0], 13'd0};
    end
    if (e == 5'h1F) return sign | EXP_MASK | {9'd0, m, 13'd0};
    return sign | {1'b0, 8'({3'd0, e} + 8'd112), m, 13'd0};
  endfunction

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // IEEE less-than; false whenever a NaN is involved.
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b1;
    return f_lt(a, b) || (a == b);
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

  // x * 1.25 rounded to nearest even, for a finite x.
  function automatic logic [31:0] mul_125(input logic [31:0] x);
    logic [7:0]  e;
    logic [23:0] mm;
    logic [26:0] p;
    logic [23:0] t;
    logic        g;
    logic        s;
    logic        inc;
    logic [8:0]  ex;
    logic [31:0] mag;
    e  = x[30:23];
    mm = {(e != 8'd0), x[22:0]};
    p  = {1'b0, mm, 2'b00} + {3'd0, mm};
    if (e == 8'd0) begin
      t = p[25:2]; g = p[1]; s = p[0];
      inc = g & (s | t[0]);
      mag = {8'd0, t} + {31'd0, inc};
    end else begin
      if (p[26]) begin
        t = p[26:3]; g = p[2]; s = |p[1:0]; ex = {1'b0, e} + 9'd1;
      end else begin
        t = p[25:2]; g = p[1]; s = p[0]; ex = {1'b0, e};
      end
      inc = g & (s | t[0]);
      mag = {ex, 23'd0} + {9'd0, t[22:0]} + {31'd0, inc};
    end
    if (mag[31:23] >= 9'd255) return {x[31], 8'hFF, 23'd0};
    return {x[31], mag[30:0]};
  endfunction

endpackage

// ===== hw/rtl/prmt_front.sv =====
// Front end: bound registers, half widening and window classification of each word.
// Depends on prmt_pkg.
module prmt_front #(
  parameter int CHANNELS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    command,
  input  logic [prmt_pkg::CH_W-1:0] channel,
  input  logic [31:0]             raw_value,
  input  logic                    is_half,
  output prmt_pkg::item_t         item
);

  logic [31:0] floor_bits;
  logic [31:0] ceiling_bits;
  logic [31:0] v;
  logic        ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_bits   <= prmt_pkg::FLOOR_RESET;
      ceiling_bits <= prmt_pkg::CEILING_RESET;
    end else if (cfg_write) begin
      unique case (prmt_pkg::reg_index_t'(cfg_index))
        prmt_pkg::REG_FLOOR:   floor_bits   <= cfg_data;
        prmt_pkg::REG_CEILING: ceiling_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    v  = is_half ? prmt_pkg::widen_half(raw_value[15:0]) : raw_value;
    ok = {28'd0, channel} < 32'(CHANNELS);
    item.channel = channel;
    item.ok      = ok;
    item.value   = command ? 32'd0 : v;
    priority if (!ok) begin
      item.outcome = prmt_pkg::OUT_IGNORED;
    end else if (command) begin
      item.outcome = prmt_pkg::OUT_CLEARED;
    end else if ((v & prmt_pkg::EXP_MASK) == prmt_pkg::EXP_MASK) begin
      item.outcome = prmt_pkg::OUT_IGNORED;
    end else if (prmt_pkg::f_le(v, floor_bits) || prmt_pkg::f_le(ceiling_bits, v)) begin
      item.outcome = prmt_pkg::OUT_OUTSIDE;
    end else begin
      item.outcome = prmt_pkg::OUT_INSIDE;
    end
  end

endmodule

// ===== hw/rtl/prmt_queue.sv =====
// Two-entry queue of classified words between the front and the back end.
// Depends on prmt_pkg for the entry type.
module prmt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  prmt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output prmt_pkg::item_t head_item
);

  prmt_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> !full)
    else $error("queue written while full");

endmodule

// ===== hw/rtl/prmt_back.sv =====
// Back end: per-channel statistics stores, update step, moves test and result register.
// Depends on prmt_pkg.
module prmt_back #(
  parameter int CHANNELS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  prmt_pkg::item_t           head_item,
  output logic                      pop,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [prmt_pkg::CH_W-1:0] channel_out,
  output logic [1:0]                outcome,
  output logic [31:0]               value_single,
  output logic [31:0]               lowest_out,
  output logic [31:0]               highest_out,
  output logic [31:0]               in_window_count,
  output logic                      moves_flag,
  output logic [31:0]               read_count
);

  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    ST_UPD  = 2'b01,
    ST_FLAG = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [31:0] lo_mem [CHANNELS];
  logic [31:0] hi_mem [CHANNELS];
  logic [31:0] wc_mem [CHANNELS];
  logic [31:0] rc_mem [CHANNELS];
  logic [CHANNELS-1:0] vld;
  logic [CHANNELS-1:0] moves;

  prmt_pkg::item_t r_item;
  logic [31:0] r_lo, r_hi, r_wc, r_rc;

  logic [IDXW-1:0] idx;
  logic [IDXW-1:0] r_idx;
  logic [31:0] cur_lo, cur_hi, cur_wc, cur_rc;
  logic [31:0] lo_next, hi_next, wc_next, rc_next;
  logic        write_en;
  logic        fire;
  logic [31:0] lim;
  logic        set_moves;
  logic        mv;

  assign idx   = IDXW'(head_item.channel);
  assign r_idx = IDXW'(r_item.channel);
  assign pop   = (state == ST_UPD) && head_valid;
  assign fire  = (state == ST_FLAG) && !(out_valid && out_stall);

  always_comb begin
    cur_lo = vld[idx] ? lo_mem[idx] : 32'd0;
    cur_hi = vld[idx] ? hi_mem[idx] : 32'd0;
    cur_wc = vld[idx] ? wc_mem[idx] : 32'd0;
    cur_rc = vld[idx] ? rc_mem[idx] : 32'd0;
    lo_next  = cur_lo;
    hi_next  = cur_hi;
    wc_next  = cur_wc;
    rc_next  = cur_rc;
    write_en = 1'b0;
    if (head_item.ok) begin
      unique case (head_item.outcome)
        prmt_pkg::OUT_CLEARED: begin
          lo_next = 32'd0;
          hi_next = 32'd0;
          wc_next = 32'd0;
          rc_next = 32'd0;
        end
        prmt_pkg::OUT_OUTSIDE: begin
          rc_next  = prmt_pkg::sat_inc(cur_rc);
          write_en = 1'b1;
        end
        prmt_pkg::OUT_INSIDE: begin
          if (cur_wc == 32'd0) begin
            lo_next = head_item.value;
            hi_next = head_item.value;
          end else begin
            if (prmt_pkg::f_lt(head_item.value, cur_lo)) lo_next = head_item.value;
            if (prmt_pkg::f_lt(cur_hi, head_item.value)) hi_next = head_item.value;
          end
          wc_next  = prmt_pkg::sat_inc(cur_wc);
          rc_next  = prmt_pkg::sat_inc(cur_rc);
          write_en = 1'b1;
        end
        prmt_pkg::OUT_IGNORED: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    lim       = prmt_pkg::mul_125(r_lo);
    set_moves = r_item.ok && (r_item.outcome == prmt_pkg::OUT_INSIDE) &&
                (r_wc > 32'd1) && prmt_pkg::f_lt(lim, r_hi);
    mv        = r_item.ok && (moves[r_idx] || set_moves);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_UPD:  if (head_valid) state_next = ST_FLAG;
      ST_FLAG: if (fire) state_next = ST_UPD;
      default: state_next = ST_UPD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && write_en) begin
      lo_mem[idx] <= lo_next;
      hi_mem[idx] <= hi_next;
      wc_mem[idx] <= wc_next;
      rc_mem[idx] <= rc_next;
    end
    if (pop) begin
      r_item <= head_item;
      r_lo   <= lo_next;
      r_hi   <= hi_next;
      r_wc   <= wc_next;
      r_rc   <= rc_next;
    end
    if (fire) begin
      channel_out     <= r_item.channel;
      outcome         <= r_item.outcome;
      value_single    <= r_item.value;
      lowest_out      <= r_item.ok ? r_lo : 32'd0;
      highest_out     <= r_item.ok ? r_hi : 32'd0;
      in_window_count <= r_item.ok ? r_wc : 32'd0;
      read_count      <= r_item.ok ? r_rc : 32'd0;
      moves_flag      <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_UPD;
      vld       <= '0;
      moves     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && head_item.ok) begin
        if (head_item.outcome == prmt_pkg::OUT_CLEARED) begin
          vld[idx]   <= 1'b0;
          moves[idx] <= 1'b0;
        end else if (write_en) begin
          vld[idx] <= 1'b1;
        end
      end
      if (fire && set_moves) moves[r_idx] <= 1'b1;
      if (fire) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_moves_needs_two: assert property (@(posedge clk) disable iff (rst)
    (out_valid && moves_flag) |-> (in_window_count > 32'd1))
    else $error("moves flag without two in-window words");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == prmt_pkg::OUT_CLEARED)) |->
      ((read_count == 32'd0) && (value_single == 32'd0) && !moves_flag))
    else $error("cleared result carries statistics");

  a_counts_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (read_count >= in_window_count))
    else $error("in-window count exceeds read count");

endmodule

// ===== hw/rtl/plausible_range_motion_tracker.sv =====
// Top level of the plausible-range motion tracker: front end, queue and back end.
// Depends on prmt_pkg, prmt_front, prmt_queue and prmt_back.
//
//   Port group   Direction  Handshake             Contents
//   in_*         input      in_valid / in_stall   command, channel, raw_value, is_half
//   out_*        output     out_valid / out_stall channel_out, outcome, value_single, stats
//   cfg_*        input      cfg_write             cfg_index selects floor or ceiling
//
// The front end widens half samples, tests them against the bounds and pushes one
// classified word per cycle into a two-entry queue while the queue has room.
// The back end takes one word at a time: in ST_UPD, a read-modify-write of the
// channel's statistics; in ST_FLAG, the lowest-times-1.25 product and compare that
// sets the moves flag and loads the result register, before the next word is popped.
// Reset clears the queue, the back-end state and per-channel valid bits, so every
// channel reads as zero; no sweep is needed. A stalled result holds the back end,
// and the queue then fills and raises in_stall.
module plausible_range_motion_tracker #(
  parameter int CHANNELS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [prmt_pkg::CH_W-1:0] channel,
  input  logic [31:0]               raw_value,
  input  logic                      is_half,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [prmt_pkg::CH_W-1:0] channel_out,
  output logic [1:0]                outcome,
  output logic [31:0]               value_single,
  output logic [31:0]               lowest_out,
  output logic [31:0]               highest_out,
  output logic [31:0]               in_window_count,
  output logic                      moves_flag,
  output logic [31:0]               read_count
);

  prmt_pkg::item_t front_item;
  prmt_pkg::item_t head_item;
  logic            q_full;
  logic            head_valid;
  logic            pop;
  logic            push;

  // A word enters the queue whenever it is offered and the queue has room.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  prmt_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command),
    .channel   (channel),
    .raw_value (raw_value),
    .is_half   (is_half),
    .item      (front_item)
  );

  prmt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  prmt_back #(.CHANNELS(CHANNELS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .channel_out     (channel_out),
    .outcome         (outcome),
    .value_single    (value_single),
    .lowest_out      (lowest_out),
    .highest_out     (highest_out),
    .in_window_count (in_window_count),
    .moves_flag      (moves_flag),
    .read_count      (read_count)
  );

endmodule
